/* src/ecr_pkg.sv */
// package: types, constants and status codes for the elapsed count to rational block
`default_nettype none
package ecr_pkg;
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        REG_SCALE_NUM = 1'b0,
        REG_SCALE_DEN = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [63:0] origin_count;
        logic [63:0] current_count;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] time_numerator;
        logic [63:0]        time_denominator;
        logic [1:0]         status;
    } t_out_item;
endpackage
`default_nettype wire

/* src/elapsed_count_to_reduced_rational.sv */
// top level: elapsed count to reduced rational converter using shift-add and subtract steps
`default_nettype none
// One item is taken when i_start is high and o_busy is low; the result appears on
// o_result for exactly one cycle, marked by o_done, and cannot be held off. Scale writes
// are taken only while the block is idle and no item is being started. After acceptance
// the block runs 64 shift-add steps for the product, one check, a binary gcd of shift or
// subtract steps with a closing step, 64 restoring division steps that form both
// quotients, then a finish state. All of it runs on one shift/subtract datapath.
// Zero-denominator and zero-product items go straight to the finish state, overflowing
// products go there from the check.
module elapsed_count_to_reduced_rational
    import ecr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_in_item  i_item,
    output logic           o_busy,
    output logic           o_done,
    output t_out_item      o_result,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [63:0] i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    t_state r_state, n_state;
    logic [63:0] r_snum, r_sden;
    logic        r_neg;
    logic [63:0] r_a, r_b;          // gcd operands / multiplier
    logic [127:0] r_acc;            // product accumulator
    logic [63:0] r_mcand;
    logic [6:0]  r_cnt;
    logic [6:0]  r_shift;           // common power of two
    logic [63:0] r_prod;
    logic [63:0] r_g;
    logic [63:0] r_qn, r_qd, r_rn, r_rd;
    t_out_item   r_res;
    logic        r_done;

    logic [63:0] w_mag;
    logic        w_start;
    assign w_start = i_start && (r_state == S_IDLE);
    assign w_mag = (i_item.current_count < i_item.origin_count)
        ? (i_item.origin_count - i_item.current_count)
        : (i_item.current_count - i_item.origin_count);

    // configuration write, only between items
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snum <= 64'd1;
            r_sden <= 64'd1;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index[63:1] == 63'd0) begin
            if (i_cfg_index[0] == REG_SCALE_NUM) r_snum <= i_cfg_data;
            else r_sden <= i_cfg_data;
        end
    end

    // gcd step signals
    logic w_a_even, w_b_even;
    logic [64:0] w_ab;
    assign w_a_even = ~r_a[0];
    assign w_b_even = ~r_b[0];
    assign w_ab = {1'b0, r_a} - {1'b0, r_b};

    // division step signals (one shift-subtract per term)
    logic [64:0] w_rn2, w_rd2;
    logic        w_n_take, w_d_take;
    logic [63:0] w_qn_next, w_qd_next;
    assign w_rn2 = {r_rn, r_qn[63]};
    assign w_rd2 = {r_rd, r_qd[63]};
    assign w_n_take = (w_rn2 >= {1'b0, r_g});
    assign w_d_take = (w_rd2 >= {1'b0, r_g});
    assign w_qn_next = {r_qn[62:0], w_n_take};
    assign w_qd_next = {r_qd[62:0], w_d_take};

    // product range check against the signed limits
    logic w_ovf;
    assign w_ovf = (r_acc[127:64] != 64'd0) ||
                   (!r_neg && r_acc[63]) ||
                   (r_neg && r_acc[63] && r_acc[62:0] != 63'd0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    if (r_sden == 64'd0 || w_mag == 64'd0 || r_snum == 64'd0)
                        n_state = S_DONE;
                    else
                        n_state = S_MUL;
                end
            end
            S_MUL:   if (r_cnt == 7'd63) n_state = S_CHECK;
            S_CHECK: n_state = w_ovf ? S_DONE : S_GCD;
            S_GCD:   if (r_b == 64'd0) n_state = S_DIV;
            S_DIV:   if (r_cnt == 7'd63) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_neg   <= i_item.current_count < i_item.origin_count;
                r_acc   <= '0;
                r_mcand <= w_mag;
                r_b     <= r_snum;
                r_cnt   <= '0;
                r_res.time_numerator   <= '0;
                r_res.time_denominator <= (r_sden == 64'd0) ? 64'd0 : 64'd1;
                r_res.status <= (r_sden == 64'd0) ? ST_ZERO_DEN : ST_OK;
            end
            S_MUL: begin
                // one shift-add step per cycle, msb of multiplier first
                r_acc <= {r_acc[126:0], 1'b0} + (r_b[63] ? {64'd0, r_mcand} : 128'd0);
                r_b   <= {r_b[62:0], 1'b0};
                r_cnt <= r_cnt + 7'd1;
            end
            S_CHECK: begin
                r_prod  <= r_acc[63:0];
                r_a     <= r_acc[63:0];
                r_b     <= r_sden;
                r_shift <= '0;
                if (w_ovf) begin
                    r_res.status <= ST_OVERFLOW;
                    r_res.time_denominator <= '0;
                end
            end
            S_GCD: begin
                // binary gcd: one shift or subtract per cycle
                if (r_b == 64'd0) begin
                    r_g   <= r_a << r_shift[5:0];
                    r_qn  <= r_prod;
                    r_qd  <= r_sden;
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_cnt <= '0;
                end else if (w_a_even && w_b_even) begin
                    r_a <= r_a >> 1; r_b <= r_b >> 1; r_shift <= r_shift + 7'd1;
                end else if (w_a_even) begin
                    r_a <= r_a >> 1;
                end else if (w_b_even) begin
                    r_b <= r_b >> 1;
                end else if (w_ab[64]) begin
                    r_b <= r_b - r_a;
                end else begin
                    // smaller term stays in a, the difference goes to b
                    r_a <= r_b;
                    r_b <= w_ab[63:0];
                end
            end
            S_DIV: begin
                // restoring division of both terms by the gcd
                r_qn <= w_qn_next;
                r_qd <= w_qd_next;
                r_rn <= w_n_take ? 64'(w_rn2 - {1'b0, r_g}) : w_rn2[63:0];
                r_rd <= w_d_take ? 64'(w_rd2 - {1'b0, r_g}) : w_rd2[63:0];
                r_cnt <= r_cnt + 7'd1;
                // last step: load the reduced fraction
                if (r_cnt == 7'd63) begin
                    r_res.time_numerator   <= r_neg ? (~w_qn_next + 64'd1) : w_qn_next;
                    r_res.time_denominator <= w_qd_next;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_busy   = (r_state != S_IDLE);
        o_done   = r_done;
        o_result = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= (r_state == S_DONE);
    end

    // assertions
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DONE)) else $error("done without finish");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status != ST_OK |-> o_result.time_numerator == 64'sd0)
        else $error("error result not zero");
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_OK |-> o_result.time_denominator != 64'd0)
        else $error("ok result with zero denominator");
endmodule
`default_nettype wire
